// File: rtl/address_range_table_top_macros.svh
// ---------------------------------------------------------------------------
// Address range table assertion macros
// Shared concurrent check forms, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_TABLE_TOP_MACROS_SVH
`define ADDRESS_RANGE_TABLE_TOP_MACROS_SVH

// property that holds at every edge out of reset
`define ART_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on the same edge
`define ART_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/art_pkg.sv
// ---------------------------------------------------------------------------
// Address range table package
// Operation and status codes plus the controller/datapath command structs.
// ---------------------------------------------------------------------------
package art_pkg;

  // request operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } art_op_t;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_RANGE = 2'd2,
    ST_NOT_FOUND = 2'd3
  } art_status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture the request transaction
    logic rd_en;    // read table entry at idx
    logic wipe_en;  // write an invalid entry at idx
    logic cmp_en;   // read data from last cycle is ready to compare
    logic commit;   // update table and load the response register
  } art_cmd_t;

  // datapath to controller status
  typedef struct packed {
    art_op_t op;
    logic    bad_range;
    logic    rsp_free;
  } art_stat_t;

endpackage

// File: rtl/address_range_table_top.sv
// Sequence: a request is captured in IDLE and decoded in DISPATCH; insert and lookup
//   walk every entry in SCAN and then DRAIN, clear sweeps the table in WIPE, and bad
//   range and unused codes go to FINISH, which commits once the response slot is free.
// Flow: one transaction at a time, as the single read port walks every table entry
//   once and requests stall until the response is committed.
// Reset: synchronous; a sweep invalidates every entry and requests stall until it ends.
// ---------------------------------------------------------------------------
// Address range table
// Non-overlapping tagged address ranges with insert, lookup and clear.
// ---------------------------------------------------------------------------
module address_range_table_top #(
  parameter int TABLE_DEPTH = 64,
  parameter int TAG_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] address,
  input  logic [31:0] size,
  input  logic [15:0] tag,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [15:0] hit_tag,
  output logic [31:0] offset,
  output logic [6:0]  evicted_count
);
  import art_pkg::*;

  art_cmd_t                       cmd;
  art_stat_t                      stat;
  logic [$clog2(TABLE_DEPTH)-1:0] idx;

  // sequencer
  art_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd),
    .idx       (idx)
  );

  // table storage and compare
  art_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .idx           (idx),
    .stat          (stat),
    .operation     (operation),
    .address       (address),
    .size          (size),
    .tag           (tag),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .hit_tag       (hit_tag),
    .offset        (offset),
    .evicted_count (evicted_count)
  );

endmodule

// File: rtl/art_ctrl.sv
// ---------------------------------------------------------------------------
// Address range table controller
// Sequences the reset sweep, the per-request table walk and the response.
// ---------------------------------------------------------------------------
module art_ctrl #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  art_pkg::art_stat_t         stat,
  output art_pkg::art_cmd_t          cmd,
  output logic [$clog2(TABLE_DEPTH)-1:0] idx
);
  import art_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

  typedef enum logic [6:0] {
    S_BOOT     = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_DISPATCH = 7'b0000100,
    S_SCAN     = 7'b0001000,
    S_DRAIN    = 7'b0010000,
    S_WIPE     = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t        state, state_next;
  logic [IW-1:0] idx_q, idx_next;
  logic          cmp_pend;

  // state, entry index and read-pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_BOOT;
      idx_q    <= '0;
      cmp_pend <= 1'b0;
    end else begin
      state    <= state_next;
      idx_q    <= idx_next;
      cmp_pend <= cmd.rd_en;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    idx_next   = idx_q;
    case (state)
      S_BOOT, S_WIPE: begin
        cmd.wipe_en = 1'b1;
        if (idx_q == LAST) begin
          idx_next   = '0;
          state_next = (state == S_BOOT) ? S_IDLE : S_FINISH;
        end else begin
          idx_next = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_INSERT: state_next = stat.bad_range ? S_FINISH : S_SCAN;
          OP_LOOKUP: state_next = S_SCAN;
          OP_CLEAR:  state_next = S_WIPE;
          default:   state_next = S_FINISH;
        endcase
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (idx_q == LAST) begin
          idx_next   = '0;
          state_next = S_DRAIN;
        end else begin
          idx_next = idx_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.rsp_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    cmd.cmp_en = cmp_pend;
  end

  assign idx       = idx_q;
  assign req_stall = (state != S_IDLE);

endmodule

// File: rtl/art_dpath.sv
// ---------------------------------------------------------------------------
// Address range table datapath
// Entry memory, overlap and hit compare, eviction count and response register.
// ---------------------------------------------------------------------------
`include "address_range_table_top_macros.svh"

module art_dpath #(
  parameter int TABLE_DEPTH = 64,
  parameter int TAG_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  art_pkg::art_cmd_t              cmd,
  input  logic [$clog2(TABLE_DEPTH)-1:0] idx,
  output art_pkg::art_stat_t             stat,
  input  logic [1:0]                     operation,
  input  logic [63:0]                    address,
  input  logic [31:0]                    size,
  input  logic [15:0]                    tag,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [1:0]                     status,
  output logic [15:0]                    hit_tag,
  output logic [31:0]                    offset,
  output logic [6:0]                     evicted_count
);
  import art_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = 1 + 64 + 64 + TAG_BITS;
  localparam int VB = EW - 1;          // valid bit
  localparam int SB = EW - 2;          // msb of start
  localparam int EB = EW - 66;         // msb of end
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  // entry memory: {valid, start, end, tag}
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd_word;
  logic [IW-1:0] rd_idx;

  // captured request
  art_op_t             op_q;
  logic [63:0]         start_q;
  logic [63:0]         end_q;
  logic [TAG_BITS-1:0] tag_q;
  logic                bad_q;

  // walk results
  logic [CW-1:0]       ev_cnt;
  logic [IW-1:0]       slot;
  logic                slot_found;
  logic                hit_found;
  logic [TAG_BITS-1:0] hit_tag_q;
  logic [31:0]         offset_q;
  logic [CW-1:0]       count;

  // response register
  art_status_t rsp_status;

  logic [31:0]         size_m1;
  logic [64:0]         end_sum;
  logic [31:0]         tag_ext;
  logic                ent_valid;
  logic [63:0]         ent_start;
  logic [63:0]         ent_end;
  logic [TAG_BITS-1:0] ent_tag;
  logic [63:0]         ent_diff;
  logic                overlap;
  logic                hit;
  logic                evict_now;
  logic                ins_ok;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;
  logic [31:0]         ev_ext;
  logic [31:0]         ht_ext;

  // range end with wrap detect
  assign size_m1 = size - 32'd1;
  assign end_sum = {1'b0, address} + {33'b0, size_m1};
  assign tag_ext = 32'(tag);

  // entry fields from the registered read
  assign ent_valid = rd_word[VB];
  assign ent_start = rd_word[SB -: 64];
  assign ent_end   = rd_word[EB -: 64];
  assign ent_tag   = rd_word[TAG_BITS-1:0];
  assign ent_diff  = start_q - ent_start;

  // overlap for insert, containment for lookup
  assign overlap   = ent_valid && (ent_start <= end_q) && (start_q <= ent_end);
  assign hit       = ent_valid && (start_q >= ent_start) && (start_q <= ent_end);
  assign evict_now = cmd.cmp_en && (op_q == OP_INSERT) && overlap;

  // insert goes ahead unless bad_q, or the table is full and nothing was evicted
  assign ins_ok = (op_q == OP_INSERT) && !bad_q &&
                  !((ev_cnt == '0) && (count == FULL_COUNT));

  // memory write port: sweep, eviction or new entry
  always_comb begin
    wr_en   = cmd.wipe_en || evict_now || (cmd.commit && ins_ok);
    wr_addr = slot;
    wr_data = '0;
    if (cmd.wipe_en) begin
      wr_addr = idx;
    end else if (evict_now) begin
      wr_addr = rd_idx;
    end else begin
      wr_data = {1'b1, start_q, end_q, tag_q};
    end
  end

  // memory access
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_word <= mem[idx];
      rd_idx  <= idx;
    end
  end

  // request capture and walk accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= art_op_t'(operation);
      start_q    <= address;
      end_q      <= end_sum[63:0];
      tag_q      <= tag_ext[TAG_BITS-1:0];
      bad_q      <= (size == 32'd0) || end_sum[64];
      ev_cnt     <= '0;
      slot       <= '0;
      slot_found <= 1'b0;
      hit_found  <= 1'b0;
      hit_tag_q  <= '0;
      offset_q   <= '0;
    end else if (cmd.cmp_en) begin
      if (evict_now) begin
        ev_cnt <= ev_cnt + 1'b1;
      end
      if ((!ent_valid || overlap) && !slot_found) begin
        slot       <= rd_idx;
        slot_found <= 1'b1;
      end
      if ((op_q == OP_LOOKUP) && hit && !hit_found) begin
        hit_found <= 1'b1;
        hit_tag_q <= ent_tag;
        offset_q  <= ent_diff[31:0];
      end
    end
  end

  // valid entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      if (ins_ok) begin
        count <= count - ev_cnt + CW'(1);
      end else if (op_q == OP_CLEAR) begin
        count <= '0;
      end
    end
  end

  assign ev_ext = 32'(ev_cnt);
  assign ht_ext = 32'(hit_tag_q);

  // response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp_status    <= ST_OK;
      hit_tag       <= '0;
      offset        <= '0;
      evicted_count <= '0;
      case (op_q)
        OP_INSERT: begin
          if (bad_q) begin
            rsp_status <= ST_BAD_RANGE;
          end else if (!ins_ok) begin
            rsp_status <= ST_FULL;
          end else begin
            evicted_count <= ev_ext[6:0];
          end
        end
        OP_LOOKUP: begin
          if (hit_found) begin
            hit_tag <= ht_ext[15:0];
            offset  <= offset_q;
          end else begin
            rsp_status <= ST_NOT_FOUND;
          end
        end
        default: begin
          rsp_status <= ST_OK;
        end
      endcase
    end
  end

  assign status         = rsp_status;
  assign stat.op        = op_q;
  assign stat.bad_range = bad_q;
  assign stat.rsp_free  = !rsp_valid || !rsp_stall;

  // checks
  `ART_IMPLY(a_commit_free, cmd.commit, !rsp_valid || !rsp_stall, "commit with response slot busy")
  `ART_IMPLY(a_rsp_from_commit, $rose(rsp_valid), $past(cmd.commit), "response without commit")
  `ART_CHECK(a_one_writer, !(evict_now && cmd.wipe_en), "eviction during table sweep")
  `ART_IMPLY(a_slot_known, cmd.commit && ins_ok, slot_found, "insert without a free slot")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Address range table testbench
// Runs a short list of directed insert, lookup and clear transactions, then
// random window, table-fill and noise sequences. Every response is checked
// against a local model of the range table or a hand-written expectation.
// Both sides idle at random, the response side holds off once for a long
// stretch, and the request side pauses once until the block has drained.
// ---------------------------------------------------------------------------
module testbench;
  import art_pkg::*;

  localparam int          TABLE_DEPTH   = 64;
  localparam int          ITEM_TARGET   = 1450;
  localparam int          HOLD_CYCLES   = 900;
  localparam int          DRAIN_CYCLES  = 20000;
  localparam int          SETTLE_CYCLES = 80;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [63:0] ADDR_TOP      = 64'hFFFF_FFFF_FFFF_FFFF;

  // one request plus an optional hand-written expected response
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] addr;
    logic [31:0] len;
    logic [15:0] tg;
    logic        known;
    art_status_t st;
    logic [15:0] hit;
    logic [31:0] off;
    logic [6:0]  ev;
  } stim_row_t;

  typedef struct packed {
    art_status_t st;
    logic [15:0] hit;
    logic [31:0] off;
    logic [6:0]  ev;
  } range_result_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        req_valid     = 1'b0;
  logic        req_stall;
  logic [1:0]  operation     = OP_INSERT;
  logic [63:0] address       = '0;
  logic [31:0] size          = '0;
  logic [15:0] tag           = '0;
  logic        rsp_valid;
  logic        rsp_stall     = 1'b0;
  logic [1:0]  status;
  logic [15:0] hit_tag;
  logic [31:0] offset;
  logic [6:0]  evicted_count;

  // model of the range table
  logic [63:0] span_lo   [TABLE_DEPTH];
  logic [63:0] span_hi   [TABLE_DEPTH];
  logic [15:0] span_tag  [TABLE_DEPTH];
  logic        span_used [TABLE_DEPTH] = '{default: 1'b0};
  int unsigned span_count = 0;

  range_result_t expected_results [$];
  int unsigned   sent_items = 0;
  int unsigned   mismatches = 0;
  logic          calm       = 1'b0;
  logic          hold_go    = 1'b0;

  // directed transactions: extremes, wrap edge, overlap eviction, clear
  stim_row_t directed_rows [0:22] = '{
    '{OP_LOOKUP, 64'h0, 32'h0, 16'h0, 1'b1, ST_NOT_FOUND, 16'h0, 32'h0, 7'd0},
    '{OP_CLEAR, 64'h0, 32'h0, 16'h0, 1'b1, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_INSERT, 64'h1000, 32'h0, 16'h0055, 1'b1, ST_BAD_RANGE, 16'h0, 32'h0, 7'd0},
    '{OP_INSERT, ADDR_TOP, 32'h2, 16'h0066, 1'b1, ST_BAD_RANGE, 16'h0, 32'h0, 7'd0},
    '{OP_INSERT, ADDR_TOP, 32'h1, 16'hFFFF, 1'b1, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_LOOKUP, ADDR_TOP, 32'h0, 16'h0, 1'b1, ST_OK, 16'hFFFF, 32'h0, 7'd0},
    '{OP_INSERT, 64'h0, 32'hFFFF_FFFF, 16'h0, 1'b0, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_LOOKUP, 64'hFFFF_FFFE, 32'h0, 16'h0, 1'b0, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_LOOKUP, 64'hFFFF_FFFF, 32'h0, 16'h0, 1'b0, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_INSERT, 64'h1000, 32'h10, 16'h1234, 1'b0, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_INSERT, 64'h2000, 32'h100, 16'hABCD, 1'b0, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_LOOKUP, 64'h1000, 32'h0, 16'h0, 1'b0, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_LOOKUP, 64'h100F, 32'h0, 16'h0, 1'b0, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_LOOKUP, 64'h1010, 32'h0, 16'h0, 1'b0, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_INSERT, 64'h0FF0, 32'h1020, 16'h0001, 1'b0, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_UNUSED, 64'hA5A5_5A5A_C3C3_3C3C, 32'h1234, 16'h4321, 1'b1, ST_OK,
      16'h0, 32'h0, 7'd0},
    '{OP_LOOKUP, 64'h2005, 32'h0, 16'h0, 1'b0, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_CLEAR, 64'h0, 32'h0, 16'h0, 1'b1, ST_OK, 16'h0, 32'h0, 7'd0},
    '{OP_LOOKUP, 64'h2005, 32'h0, 16'h0, 1'b1, ST_NOT_FOUND, 16'h0, 32'h0, 7'd0},
    '{OP_INSERT, 64'hFFFF_FFFF_0000_0000, 32'hFFFF_FFFF, 16'h8000, 1'b0, ST_OK,
      16'h0, 32'h0, 7'd0},
    '{OP_INSERT, 64'hFFFF_FFFF_0000_0001, 32'hFFFF_FFFF, 16'h7FFF, 1'b0, ST_OK,
      16'h0, 32'h0, 7'd0},
    '{OP_INSERT, 64'hFFFF_FFFF_0000_0002, 32'hFFFF_FFFF, 16'h0001, 1'b1, ST_BAD_RANGE,
      16'h0, 32'h0, 7'd0},
    '{OP_LOOKUP, 64'hFFFF_FFFF_8000_0000, 32'h0, 16'h0, 1'b0, ST_OK, 16'h0, 32'h0, 7'd0}
  };

  address_range_table_top #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TAG_BITS    (16)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .operation     (operation),
    .address       (address),
    .size          (size),
    .tag           (tag),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .hit_tag       (hit_tag),
    .offset        (offset),
    .evicted_count (evicted_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #20ms;
    $display("address_range_table_top: mismatch");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("[%0t] response error: %s", $time, what);
  endtask

  // apply one transaction to the table model and return its response
  function automatic range_result_t apply_range_op(logic [1:0] op, logic [63:0] addr,
                                                   logic [31:0] len, logic [15:0] tg);
    range_result_t r;
    logic [63:0]   last;
    logic [63:0]   gap;
    int unsigned   hits;
    int            free_slot;
    logic          found;
    r = '0;
    r.st = ST_OK;
    case (op)
      OP_INSERT: begin
        last = addr + {32'd0, len} - 64'd1;
        if (len == 32'd0 || addr > ADDR_TOP - ({32'd0, len} - 64'd1)) begin
          r.st = ST_BAD_RANGE;
        end else begin
          hits = 0;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (span_used[i] && span_lo[i] <= last && addr <= span_hi[i]) hits++;
          if (hits == 0 && span_count >= TABLE_DEPTH) begin
            r.st = ST_FULL;
          end else begin
            // drop every overlapping range, then take the lowest free slot
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (span_used[i] && span_lo[i] <= last && addr <= span_hi[i]) begin
                span_used[i] = 1'b0;
                span_count--;
              end
            end
            free_slot = -1;
            for (int i = 0; i < TABLE_DEPTH; i++)
              if (!span_used[i] && free_slot < 0) free_slot = i;
            if (free_slot >= 0) begin
              span_lo[free_slot]   = addr;
              span_hi[free_slot]   = last;
              span_tag[free_slot]  = tg;
              span_used[free_slot] = 1'b1;
              span_count++;
            end
            r.ev = hits[6:0];
          end
        end
      end
      OP_LOOKUP: begin
        found = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (!found && span_used[i] && addr >= span_lo[i] && addr <= span_hi[i]) begin
            found = 1'b1;
            gap   = addr - span_lo[i];
            r.hit = span_tag[i];
            r.off = gap[31:0];
          end
        end
        if (!found) r.st = ST_NOT_FOUND;
      end
      OP_CLEAR: begin
        span_used  = '{default: 1'b0};
        span_count = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t make_row(logic [1:0] op, logic [63:0] addr,
                                         logic [31:0] len, logic [15:0] tg);
    stim_row_t row;
    row      = '0;
    row.op   = op;
    row.addr = addr;
    row.len  = len;
    row.tg   = tg;
    row.st   = ST_OK;
    return row;
  endfunction

  // an address on, inside or just outside a stored range, or at random near base
  function automatic logic [63:0] near_stored(logic [63:0] base);
    int unsigned n;
    int unsigned want;
    n = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) if (span_used[i]) n++;
    if (n == 0 || $urandom_range(0, 9) < 2) return base + $urandom_range(0, 8191);
    want = $urandom_range(0, n - 1);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (span_used[i]) begin
        if (want == 0) begin
          case ($urandom_range(0, 4))
            0: return span_lo[i];
            1: return span_hi[i];
            2: return span_hi[i] + 64'd1;
            3: return span_lo[i] - 64'd1;
            default: return span_lo[i] + ({32'd0, $urandom} % (span_hi[i] - span_lo[i] + 64'd1));
          endcase
        end
        want--;
      end
    end
    return base;
  endfunction

  // at least 4 GB of headroom above the window; only random-size inserts can wrap
  function automatic logic [63:0] window_base();
    return {$urandom_range(0, 32'hFFFF_FFFE), $urandom};
  endfunction

  // one transaction of a mixed sequence inside a small address window
  function automatic stim_row_t window_item(logic [63:0] base);
    int unsigned roll;
    logic [31:0] len;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      case ($urandom_range(0, 19))
        0:       len = $urandom;
        1, 2, 3: len = $urandom_range(1, 65536);
        default: len = $urandom_range(1, 512);
      endcase
      return make_row(OP_INSERT, base + $urandom_range(0, 4095), len, 16'($urandom));
    end
    if (roll < 90) return make_row(OP_LOOKUP, near_stored(base), $urandom, 16'($urandom));
    if (roll < 96) begin
      // zero size or an end past the top of the address space
      if ($urandom_range(0, 1))
        return make_row(OP_INSERT, base + $urandom_range(0, 4095), 32'd0, 16'($urandom));
      return make_row(OP_INSERT, ADDR_TOP - $urandom_range(0, 1000),
                      $urandom_range(1002, 32'hFFFF_FFFF), 16'($urandom));
    end
    if (roll < 98)
      return make_row(OP_UNUSED, {$urandom, $urandom}, $urandom, 16'($urandom));
    return make_row(OP_CLEAR, {$urandom, $urandom}, $urandom, 16'($urandom));
  endfunction

  // offer one request transaction and record its expected response
  task automatic send(input stim_row_t row);
    range_result_t want;
    if (!calm && $urandom_range(0, 99) < 37) begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3)) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    operation <= row.op;
    address   <= row.addr;
    size      <= row.len;
    tag       <= row.tg;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    want = apply_range_op(row.op, row.addr, row.len, row.tg);
    if (row.known) want = '{row.st, row.hit, row.off, row.ev};
    expected_results.push_back(want);
    sent_items++;
  endtask

  // response side: check, then pick the stall for the next cycle
  initial begin : response_side
    range_result_t want;
    int unsigned   hold_left;
    logic          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("response with nothing pending");
        end else begin
          want = expected_results.pop_front();
          if (status !== want.st)
            flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
          if (hit_tag !== want.hit)
            flag_mismatch($sformatf("hit_tag %h, want %h", hit_tag, want.hit));
          if (offset !== want.off)
            flag_mismatch($sformatf("offset %h, want %h", offset, want.off));
          if (evicted_count !== want.ev)
            flag_mismatch($sformatf("evicted_count %0d, want %0d", evicted_count, want.ev));
        end
      end
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 37) begin
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // request side: reset, directed list, random sequences, drain
  initial begin : request_side
    logic [63:0] base;
    logic [63:0] stride;
    int unsigned pick;
    int unsigned count_down;
    logic        drained_once;
    drained_once = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) send(directed_rows[k]);

    while (sent_items < ITEM_TARGET) begin
      // long response hold-off, one full drain, then a stretch with no idling
      if (sent_items >= 400) hold_go = 1'b1;
      if (!drained_once && sent_items >= 700) begin
        drained_once = 1'b1;
        req_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end
      calm = (sent_items >= 900 && sent_items < 1100);

      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // fill the table with disjoint ranges past full, then evict them at once
        if ($urandom_range(0, 1)) send(make_row(OP_CLEAR, '0, '0, '0));
        base   = window_base();
        stride = 64'd1 << $urandom_range(4, 12);
        for (int k = 0; k < 68; k++)
          send(make_row(OP_INSERT, base + k * stride, $urandom_range(1, 32'(stride)),
                        16'($urandom)));
        repeat (6)
          send(make_row(OP_LOOKUP, near_stored(base), $urandom, 16'($urandom)));
        send(make_row(OP_INSERT, base, 32'(68 * stride), 16'($urandom)));
      end else if (pick < 80) begin
        base = window_base();
        repeat (30) send(window_item(base));
      end else begin
        repeat (10)
          send(make_row(2'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom,
                        16'($urandom)));
      end
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    count_down = DRAIN_CYCLES;
    while (expected_results.size() != 0 && count_down != 0) begin
      @(posedge clk);
      count_down--;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      flag_mismatch($sformatf("%0d responses never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("address_range_table_top: match");
    end else begin
      $display("address_range_table_top: mismatch");
    end
    $finish;
  end

endmodule
